### hdl/ptpd_pkg.sv
// ptpd_pkg: shared types and constants for the point transform / perspective divide unit.
// Used by every module under hdl/. No dependencies.
package ptpd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int XW         = 32;
  localparam int PROD_W     = 2 * XW;
  localparam int ACC_W      = PROD_W + 2;
  localparam int QBITS      = XW;
  localparam int REM_W      = ACC_W + QBITS;
  localparam int MAT_N      = 16;
  localparam int BIT_W      = $clog2(QBITS);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [3:0]           entry_index;
    logic signed [XW-1:0] entry_value;
    logic signed [XW-1:0] point_x;
    logic signed [XW-1:0] point_y;
    logic signed [XW-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [XW-1:0] out_x;
    logic signed [XW-1:0] out_y;
    logic signed [XW-1:0] out_z;
    logic                 w_zero;
    logic                 saturated;
  } out_item_t;

  typedef logic [MAT_N-1:0][XW-1:0] mat_t;

  // Dot-product results: c[0..2] coordinates, c[3] homogeneous w
  typedef struct packed {
    logic                     valid;
    logic [2:0][XW-1:0]       pt;
    logic [3:0][ACC_W-1:0]    c;
  } dot_t;

  // One coordinate in flight through the divider
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic             wz;
    logic [ACC_W-1:0] den;
    lane_t [2:0]      lane;
  } div_stage_t;

endpackage

### hdl/ptpd_dot.sv
// ptpd_dot: two-stage multiply and accumulate of the matrix rows against (x, y, z, 1).
// Depends on ptpd_pkg.
module ptpd_dot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              xform,
  input  ptpd_pkg::in_item_t in_item,
  input  ptpd_pkg::mat_t    mat,
  output ptpd_pkg::dot_t    dot_o
);
  import ptpd_pkg::*;

  logic                     valid1_r;
  logic signed [PROD_W-1:0] prod_r [4][3];
  logic signed [XW-1:0]     tr_r [4];
  logic [2:0][XW-1:0]       pt1_r;
  logic signed [XW-1:0]     pt [3];
  dot_t                     dot_r;
  dot_t                     dot_nxt;

  assign pt[0] = in_item.point_x;
  assign pt[1] = in_item.point_y;
  assign pt[2] = in_item.point_z;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      dot_r.valid <= 1'b0;
    end else if (adv) begin
      valid1_r    <= xform;
      dot_r.valid <= valid1_r;
    end
  end

  // Form the twelve products and hold the translation column
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r][k] <= $signed(mat[k*4+r]) * pt[k];
        end
        tr_r[r] <= $signed(mat[12+r]);
      end
      pt1_r <= {pt[2], pt[1], pt[0]};
    end
  end

  // Sum each row at full precision
  always_comb begin
    dot_nxt = dot_r;
    dot_nxt.pt = pt1_r;
    for (int r = 0; r < 4; r++) begin
      dot_nxt.c[r] = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) + ACC_W'(prod_r[r][2])
                     + (ACC_W'(tr_r[r]) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r.pt <= dot_nxt.pt;
      dot_r.c  <= dot_nxt.c;
    end
  end

  assign dot_o = dot_r;

endmodule

### hdl/ptpd_prep.sv
// ptpd_prep: sign split, zero-w detect and overflow precheck ahead of the divider.
// Depends on ptpd_pkg.
module ptpd_prep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  ptpd_pkg::dot_t         dot_i,
  output ptpd_pkg::div_stage_t   st_o
);
  import ptpd_pkg::*;

  logic               p1_valid_r;
  logic               p1_wz_r;
  logic [ACC_W-1:0]   p1_den_r;
  logic [ACC_W-1:0]   p1_mag_r [3];
  logic               p1_neg_r [3];
  logic [2:0][XW-1:0] p1_pt_r;
  logic [ACC_W-1:0]   w;
  logic [ACC_W-1:0]   den_nxt;
  logic [ACC_W-1:0]   mag_nxt [3];
  logic               neg_nxt [3];
  div_stage_t         st_r;
  div_stage_t         st_nxt;

  // Take magnitudes and quotient signs
  always_comb begin
    w       = dot_i.c[3];
    den_nxt = w[ACC_W-1] ? ACC_W'(0) - w : w;
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = dot_i.c[k][ACC_W-1] ? ACC_W'(0) - dot_i.c[k] : dot_i.c[k];
      neg_nxt[k] = dot_i.c[k][ACC_W-1] ^ w[ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      st_r.valid <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= dot_i.valid;
      st_r.valid <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_wz_r  <= (w == '0);
      p1_den_r <= den_nxt;
      p1_pt_r  <= dot_i.pt;
      for (int k = 0; k < 3; k++) begin
        p1_mag_r[k] <= mag_nxt[k];
        p1_neg_r[k] <= neg_nxt[k];
      end
    end
  end

  // Scale numerators, flag quotients of 2^32 or more; zero w carries the point in q
  always_comb begin
    st_nxt       = st_r;
    st_nxt.wz    = p1_wz_r;
    st_nxt.den   = p1_den_r;
    for (int k = 0; k < 3; k++) begin
      st_nxt.lane[k].rem = REM_W'(p1_mag_r[k]) << FRAC_BITS;
      st_nxt.lane[k].ovf = (REM_W'(p1_mag_r[k]) << FRAC_BITS) >= (REM_W'(p1_den_r) << QBITS);
      st_nxt.lane[k].neg = p1_neg_r[k];
      st_nxt.lane[k].q   = p1_wz_r ? p1_pt_r[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r.wz   <= st_nxt.wz;
      st_r.den  <= st_nxt.den;
      st_r.lane <= st_nxt.lane;
    end
  end

  assign st_o = st_r;

endmodule

### hdl/ptpd_div_step.sv
// ptpd_div_step: one registered restoring-division step producing one quotient bit per lane.
// Depends on ptpd_pkg.
module ptpd_div_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [ptpd_pkg::BIT_W-1:0]  bit_idx,
  input  ptpd_pkg::div_stage_t        st_i,
  output ptpd_pkg::div_stage_t        st_o
);
  import ptpd_pkg::*;

  logic [REM_W-1:0] dsh;
  div_stage_t       st_r;
  div_stage_t       st_nxt;

  // Compare and subtract the shifted divisor; skip on zero w or known overflow
  always_comb begin
    st_nxt = st_i;
    dsh    = REM_W'(st_i.den) << bit_idx;
    for (int k = 0; k < 3; k++) begin
      if (!st_i.wz && !st_i.lane[k].ovf && (st_i.lane[k].rem >= dsh)) begin
        st_nxt.lane[k].rem        = st_i.lane[k].rem - dsh;
        st_nxt.lane[k].q[bit_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r.valid <= st_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r.wz   <= st_nxt.wz;
      st_r.den  <= st_nxt.den;
      st_r.lane <= st_nxt.lane;
    end
  end

  assign st_o = st_r;

endmodule

### hdl/point_transform_perspective_divide_unit.sv
// Homogeneous 4x4 point transform with perspective divide, Q16.16 fixed point.
// Depends on ptpd_pkg, ptpd_dot, ptpd_prep and ptpd_div_step.
//
// Usage:
//   Input channel (in_valid/in_stall/in_item): op OP_LOAD writes matrix entry
//   entry_index (column*4+row) at acceptance and gives no result; op OP_XFORM
//   transforms (point_x, point_y, point_z, 1). The next transaction already
//   sees an entry loaded in the previous cycle.
//   Result channel (out_valid/out_stall/out_item): one transaction per transform,
//   in order. w_zero flags a zero w (point passed through), saturated flags a
//   clamped coordinate.
// Timing: one transaction per cycle unless a stalled result holds the pipeline; a transform
//   result passes 2 multiply/sum stages, 2 prep stages, 32 one-bit divide stages and the
//   output register. The 32 quotient bits set the depth.
// Reset: synchronous rst_n clears the pipeline and loads the identity matrix.
// Stall: while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; no transaction is lost or repeated.
module point_transform_perspective_divide_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptpd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptpd_pkg::out_item_t  out_item
);
  import ptpd_pkg::*;

  logic        adv;
  logic        in_acc;
  mat_t        mat_r;
  dot_t        dot;
  div_stage_t  div_st [QBITS+1];
  div_stage_t  last;
  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;
  logic [XW-1:0] res [3];
  logic          sat [3];

  // Pipeline moves unless a held result is stalled
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // Matrix entry load; identity on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_N; i++) begin
        mat_r[i] <= (i % 5 == 0) ? XW'(1) << FRAC_BITS : '0;
      end
    end else if (in_acc && in_item.op == OP_LOAD) begin
      mat_r[in_item.entry_index] <= in_item.entry_value;
    end
  end

  ptpd_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .xform   (in_acc && in_item.op == OP_XFORM),
    .in_item (in_item),
    .mat     (mat_r),
    .dot_o   (dot)
  );

  ptpd_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .dot_i (dot),
    .st_o  (div_st[0])
  );

  // Quotient bits, most significant first
  for (genvar g = 0; g < QBITS; g++) begin : g_div
    ptpd_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .bit_idx (BIT_W'(QBITS - 1 - g)),
      .st_i    (div_st[g]),
      .st_o    (div_st[g+1])
    );
  end

  assign last = div_st[QBITS];

  // Apply sign and clamp
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[k] = last.lane[k].q;
      sat[k] = 1'b0;
      if (!last.wz) begin
        if (last.lane[k].neg) begin
          if (last.lane[k].ovf || last.lane[k].q > {1'b1, {(XW-1){1'b0}}}) begin
            res[k] = {1'b1, {(XW-1){1'b0}}};
            sat[k] = 1'b1;
          end else begin
            res[k] = XW'(0) - last.lane[k].q;
          end
        end else if (last.lane[k].ovf || last.lane[k].q[XW-1]) begin
          res[k] = {1'b0, {(XW-1){1'b1}}};
          sat[k] = 1'b1;
        end
      end
    end
    out_item_nxt.out_x     = res[0];
    out_item_nxt.out_y     = res[1];
    out_item_nxt.out_z     = res[2];
    out_item_nxt.w_zero    = last.wz;
    out_item_nxt.saturated = sat[0] | sat[1] | sat[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.w_zero && out_item.saturated))
    else $error("w_zero and saturated both set");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");
`endif

endmodule

### tb/point_transform_perspective_divide_unit_tb.sv
// Testbench for point_transform_perspective_divide_unit: matrix loads and point
// transforms checked against an in-bench fixed-point predictor.
// Depends on ptpd_pkg and the unit RTL only.
module point_transform_perspective_divide_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptpd_pkg::*;

  localparam int LATENCY = 37;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  // Predictor copy of the matrix and queue of predicted transform results
  logic signed [31:0] pred_matrix [16];
  out_item_t expected_points [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;

  point_transform_perspective_divide_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic void reset_matrix();
    for (int i = 0; i < 16; i++) pred_matrix[i] = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
  endfunction

  function automatic logic signed [127:0] row_dot(input int row, input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] z);
    logic signed [127:0] s;
    s = 128'(pred_matrix[row]) * 128'(x);
    s += 128'(pred_matrix[row + 4]) * 128'(y);
    s += 128'(pred_matrix[row + 8]) * 128'(z);
    s += 128'(pred_matrix[row + 12]) <<< FRAC_BITS;
    return s;
  endfunction

  // Truncating divide with clamp to 32-bit signed
  function automatic logic [31:0] divide_clamp(input logic signed [127:0] num,
      input logic signed [127:0] den, inout logic sat);
    logic signed [127:0] q;
    q = (num <<< FRAC_BITS) / den;
    if (q > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (q < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic void predict_item(input in_item_t it);
    logic signed [127:0] w;
    out_item_t r;
    logic sat;
    if (it.op == OP_LOAD) begin
      pred_matrix[it.entry_index] = it.entry_value;
      return;
    end
    w = row_dot(3, it.point_x, it.point_y, it.point_z);
    sat = 1'b0;
    if (w == 0) begin
      r = '{it.point_x, it.point_y, it.point_z, 1'b1, 1'b0};
    end else begin
      r.out_x = divide_clamp(row_dot(0, it.point_x, it.point_y, it.point_z), w, sat);
      r.out_y = divide_clamp(row_dot(1, it.point_x, it.point_y, it.point_z), w, sat);
      r.out_z = divide_clamp(row_dot(2, it.point_x, it.point_y, it.point_z), w, sat);
      r.w_zero = 1'b0;
      r.saturated = sat;
    end
    expected_points.push_back(r);
  endfunction

  // Receiver stall and result checking
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", out_item.out_x, 32'h0);
      end else begin
        want = expected_points.pop_front();
        if (out_item.out_x !== want.out_x) report_mismatch("out_x", out_item.out_x, want.out_x);
        if (out_item.out_y !== want.out_y) report_mismatch("out_y", out_item.out_y, want.out_y);
        if (out_item.out_z !== want.out_z) report_mismatch("out_z", out_item.out_z, want.out_z);
        if (out_item.w_zero !== want.w_zero)
          report_mismatch("w_zero", 32'(out_item.w_zero), 32'(want.w_zero));
        if (out_item.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_item.saturated), 32'(want.saturated));
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Send one transaction; hold it until accepted, drop valid only on an idle cycle
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    @(negedge clk);
  endtask

  function automatic in_item_t load_item(input int idx, input logic [31:0] val);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.entry_index = 4'(idx);
    it.entry_value = val;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    return it;
  endfunction

  function automatic in_item_t xform_item(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
    in_item_t it;
    it.op = OP_XFORM;
    it.entry_index = 4'($urandom);
    it.entry_value = $urandom;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(2047)) - 1024) <<< 16;
      3: return 32'($signed($urandom_range(65535)) - 32768);
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
    endcase
  endfunction

  task automatic test_identity_extremes();
    send_item(xform_item(32'h7FFFFFFF, 32'h80000000, 32'h0));
    send_item(xform_item(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
    send_item(xform_item(32'h00010000, 32'hFFFF0000, 32'h00000001));
  endtask

  // Perspective row: w = z, so z = 0 gives w zero
  task automatic test_w_zero_and_saturation();
    send_item(load_item(15, 32'h0));
    send_item(load_item(11, 32'h00010000));
    send_item(xform_item(32'h12345678, 32'h80000000, 32'h0));
    send_item(xform_item(32'h7FFFFFFF, 32'h80000000, 32'h00000001));
    send_item(xform_item(32'h00030000, 32'hFFFD0000, 32'hFFFFFFFF));
    send_item(load_item(11, 32'h80000000));
    send_item(load_item(0, 32'h7FFFFFFF));
    send_item(xform_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000100));
    send_item(xform_item(32'h80000000, 32'h00000001, 32'h7FFFFFFF));
    send_item(load_item(15, 32'hFFFFFFFF));
    send_item(load_item(12, 32'h80000000));
    send_item(xform_item(32'h0, 32'h0, 32'h0));
    send_item(xform_item(32'h80000000, 32'h80000000, 32'h80000000));
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        send_item(load_item($urandom_range(15),
                  $urandom_range(2) == 0 ? $urandom : rand_coord()));
      end else begin
        send_item(xform_item(rand_coord(), rand_coord(), $urandom_range(9) == 0 ?
                  32'h0 : rand_coord()));
      end
    end
  endtask

  task automatic wait_drain();
    while (expected_points.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  initial begin
    reset_matrix();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 6;
    recv_stall_pct = 52;
    test_identity_extremes();
    test_w_zero_and_saturation();
    test_random_mix(540);
    send_idle_pct = 52;
    recv_stall_pct = 6;
    test_random_mix(540);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(550);
    in_valid <= 1'b0;
    wait_drain();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
